// ===== sv/raf_pkg.sv =====
`default_nettype none

package raf_pkg;

    localparam int WINDOW_MAX_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SUM_W_DEF       = SAMPLE_BITS_DEF + $clog2(WINDOW_MAX_DEF);
    localparam int LEN_W_DEF       = $clog2(WINDOW_MAX_DEF + 1);

    localparam int CFG_LEN_W  = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b1;

    localparam logic MODE_HIGHPASS = 1'b0;
    localparam logic MODE_LOWPASS  = 1'b1;

    localparam logic [CFG_LEN_W-1:0] LEN_RESET = 11'd2;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_FILL    = 2'd1,
        OP_SAVE    = 2'd2,
        OP_RESTORE = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_COPY,
        ST_RD_OLD,
        ST_UPDATE,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== sv/raf_in_if.sv =====
`default_nettype none

interface raf_in_if #(
    parameter int SAMPLE_BITS = raf_pkg::SAMPLE_BITS_DEF
);
    import raf_pkg::*;

    logic                          valid;
    logic                          ready;
    t_opcode                       opcode;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output opcode, output sample, input ready);
    modport sink   (input valid, input opcode, input sample, output ready);

endinterface

`default_nettype wire

// ===== sv/raf_out_if.sv =====
`default_nettype none

interface raf_out_if #(
    parameter int SAMPLE_BITS = raf_pkg::SAMPLE_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_BITS:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);

endinterface

`default_nettype wire

// ===== sv/raf_div.sv =====
`default_nettype none

module raf_div #(
    parameter int DIVIDEND_W = raf_pkg::SUM_W_DEF,
    parameter int DIVISOR_W  = raf_pkg::LEN_W_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DIVIDEND_W-1:0] i_dividend,
    input  logic        [DIVISOR_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic signed [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_count;
    logic                  r_neg;
    logic [DIVIDEND_W-1:0] r_mag;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0] trial;
    logic [DIVISOR_W:0] diff;
    logic               ge;

    // one quotient bit per cycle, sign fixed in a final step
    assign trial = {r_rem, r_mag[DIVIDEND_W-1]};
    assign ge    = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= CNT_W'(DIVIDEND_W);
                r_neg   <= i_dividend[DIVIDEND_W-1];
                r_mag   <= i_dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-i_dividend)
                                                    : DIVIDEND_W'(i_dividend);
                r_rem   <= '0;
                r_div   <= i_divisor;
            end else if (r_busy) begin
                if (r_count != '0) begin
                    r_rem   <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                    r_mag   <= {r_mag[DIVIDEND_W-2:0], ge};
                    r_count <= r_count - CNT_W'(1);
                end else begin
                    r_mag  <= r_neg ? DIVIDEND_W'(-r_mag) : r_mag;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = signed'(r_mag);

endmodule

`default_nettype wire

// ===== sv/running_average_filter_core.sv =====
`default_nettype none

// Boxcar running-average filter over a circular window of up to WINDOW_MAX samples.
// After reset the block sweeps both sample memories to zero and takes no item
// meanwhile. An ordinary sample costs a read of the oldest entry, a write and a
// restoring divide of the running sum by the window length at one quotient bit per
// cycle. A fill with an offset writes one entry per cycle, and the first sample after
// reset does the same plus its output step; save and restore copy one entry per
// cycle between the two memories, reading one entry while writing the previous one.
// One item is in work at a time; the result register lets the next item start while
// a result still waits for its transfer. Configuration is written through a plain
// write port; the user must write it only while the block is idle, which the block
// itself does not enforce. Window lengths below 2 or above WINDOW_MAX are clamped.
module running_average_filter_core #(
    parameter int WINDOW_MAX  = raf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = raf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [raf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [raf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    raf_in_if.sink                           i_in,
    raf_out_if.source                        o_res
);

    import raf_pkg::*;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);
    localparam int RES_W = SUM_W + 1;
    localparam int OUT_W = SAMPLE_BITS + 1;
    localparam int CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;

    localparam logic signed [RES_W-1:0] OUT_HI =
        {{(RES_W - SAMPLE_BITS){1'b0}}, {SAMPLE_BITS{1'b1}}};
    localparam logic signed [RES_W-1:0] OUT_LO = ~OUT_HI;

    t_state n_state;
    t_state r_state;

    logic                          r_filter_mode;
    logic [CFG_LEN_W-1:0]          r_window_length;
    t_opcode                       r_op;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [LEN_W-1:0]              r_len;
    logic [LEN_W-1:0]              r_cnt;
    logic [IDX_W-1:0]              r_wr_idx;
    logic [IDX_W-1:0]              r_snap_idx;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [SUM_W-1:0]       r_snap_sum;
    logic                          r_first;
    logic signed [RES_W-1:0]       r_result;
    logic                          r_out_valid;
    logic signed [OUT_W-1:0]       r_out_filtered;

    logic [SAMPLE_BITS-1:0] r_win_mem  [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] r_snap_mem [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] r_win_rdata;
    logic [SAMPLE_BITS-1:0] r_snap_rdata;

    logic                   win_we;
    logic [IDX_W-1:0]       win_waddr;
    logic [SAMPLE_BITS-1:0] win_wdata;
    logic [IDX_W-1:0]       win_raddr;
    logic                   snap_we;
    logic [IDX_W-1:0]       snap_waddr;
    logic [SAMPLE_BITS-1:0] snap_wdata;
    logic [IDX_W-1:0]       snap_raddr;

    logic                    in_ready;
    logic                    in_xfer;
    logic                    div_start;
    logic                    div_done;
    logic signed [SUM_W-1:0] div_q;

    logic [CMP_W-1:0]        len_cfg_ext;
    logic [LEN_W-1:0]        len_eff;
    logic [LEN_W-1:0]        wr_ext;
    logic [LEN_W-1:0]        start_idx;
    logic [LEN_W-1:0]        cnt_m1;
    logic                    last_fill;
    logic                    last_copy;
    logic                    out_free;
    logic signed [SUM_W-1:0] x_ext;
    logic signed [SUM_W-1:0] old_ext;
    logic signed [SUM_W-1:0] fill_sum;
    logic signed [SUM_W-1:0] upd_sum;
    logic [LEN_W-1:0]        nidx_raw;
    logic [LEN_W-1:0]        nidx;
    logic [LEN_W:0]          ctr_raw;
    logic [LEN_W:0]          ctr;
    logic signed [RES_W-1:0] ctr_ext;
    logic signed [RES_W-1:0] q_ext;
    logic signed [OUT_W-1:0] sat_out;

    // effective window length
    assign len_cfg_ext = CMP_W'(r_window_length);

    always_comb begin
        if (len_cfg_ext < CMP_W'(2)) begin
            len_eff = LEN_W'(2);
        end else if (len_cfg_ext > CMP_W'(WINDOW_MAX)) begin
            len_eff = LEN_W'(WINDOW_MAX);
        end else begin
            len_eff = LEN_W'(len_cfg_ext);
        end
    end

    assign wr_ext    = LEN_W'(r_wr_idx);
    assign start_idx = (wr_ext < len_eff) ? wr_ext : '0;
    assign cnt_m1    = r_cnt - LEN_W'(1);
    assign last_fill = (r_cnt == r_len - LEN_W'(1));
    assign last_copy = (r_cnt == r_len);
    assign in_xfer   = i_in.valid && in_ready;
    assign out_free  = !r_out_valid || o_res.ready;

    assign x_ext    = {{(SUM_W - SAMPLE_BITS){r_x[SAMPLE_BITS-1]}}, r_x};
    assign old_ext  = {{(SUM_W - SAMPLE_BITS){r_win_rdata[SAMPLE_BITS-1]}}, r_win_rdata};
    assign fill_sum = r_sum + x_ext;
    assign upd_sum  = r_sum - old_ext + x_ext;

    // pointer advance and window centre
    assign nidx_raw = r_cnt + LEN_W'(1);
    assign nidx     = (nidx_raw >= r_len) ? '0 : nidx_raw;
    assign ctr_raw  = {1'b0, nidx} + {1'b0, r_len >> 1};
    assign ctr      = (ctr_raw >= {1'b0, r_len}) ? ctr_raw - {1'b0, r_len} : ctr_raw;

    assign ctr_ext = {{(RES_W - SAMPLE_BITS){r_win_rdata[SAMPLE_BITS-1]}}, r_win_rdata};
    assign q_ext   = {div_q[SUM_W-1], div_q};

    always_comb begin
        if (r_result > OUT_HI) begin
            sat_out = OUT_HI[OUT_W-1:0];
        end else if (r_result < OUT_LO) begin
            sat_out = OUT_LO[OUT_W-1:0];
        end else begin
            sat_out = r_result[OUT_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_cnt == LEN_W'(WINDOW_MAX - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    case (i_in.opcode)
                        OP_SAMPLE: n_state = r_first ? ST_FILL : ST_RD_OLD;
                        OP_FILL:   n_state = ST_FILL;
                        default:   n_state = ST_COPY;
                    endcase
                end
            end
            ST_FILL: begin
                if (last_fill) begin
                    n_state = (r_op == OP_FILL) ? ST_IDLE : ST_OUT;
                end
            end
            ST_COPY: begin
                if (last_copy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD_OLD: n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory and handshake controls
    always_comb begin
        in_ready   = 1'b0;
        div_start  = 1'b0;
        win_we     = 1'b0;
        win_waddr  = r_cnt[IDX_W-1:0];
        win_wdata  = r_x;
        win_raddr  = r_cnt[IDX_W-1:0];
        snap_we    = 1'b0;
        snap_waddr = r_cnt[IDX_W-1:0];
        snap_wdata = r_x;
        snap_raddr = r_cnt[IDX_W-1:0];
        case (r_state)
            ST_CLEAR: begin
                win_we     = 1'b1;
                win_wdata  = '0;
                snap_we    = 1'b1;
                snap_wdata = '0;
            end
            ST_IDLE: begin
                in_ready = 1'b1;
            end
            ST_FILL: begin
                win_we  = 1'b1;
                snap_we = (r_op == OP_FILL);
            end
            ST_COPY: begin
                win_waddr  = cnt_m1[IDX_W-1:0];
                snap_waddr = cnt_m1[IDX_W-1:0];
                win_wdata  = r_snap_rdata;
                snap_wdata = r_win_rdata;
                if (r_op == OP_SAVE) begin
                    snap_we = (r_cnt != '0);
                end else begin
                    win_we = (r_cnt != '0);
                end
            end
            ST_UPDATE: begin
                win_we    = 1'b1;
                div_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (win_we) begin
            r_win_mem[win_waddr] <= win_wdata;
        end
        r_win_rdata <= r_win_mem[win_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (snap_we) begin
            r_snap_mem[snap_waddr] <= snap_wdata;
        end
        r_snap_rdata <= r_snap_mem[snap_raddr];
    end

    raf_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (LEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (upd_sum),
        .i_divisor  (r_len),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_CLEAR;
            r_cnt           <= '0;
            r_filter_mode   <= MODE_LOWPASS;
            r_window_length <= LEN_RESET;
            r_wr_idx        <= '0;
            r_snap_idx      <= '0;
            r_sum           <= '0;
            r_snap_sum      <= '0;
            r_first         <= 1'b1;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FILTER_MODE:   r_filter_mode   <= i_cfg_data[0];
                    CFG_WINDOW_LENGTH: r_window_length <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    r_cnt <= r_cnt + LEN_W'(1);
                end
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_op  <= i_in.opcode;
                        r_x   <= i_in.sample;
                        r_len <= len_eff;
                        r_cnt <= (i_in.opcode == OP_SAMPLE && !r_first) ? start_idx : '0;
                        if (i_in.opcode == OP_FILL || (i_in.opcode == OP_SAMPLE && r_first))
                        begin
                            r_sum <= '0;
                        end
                    end
                end
                ST_FILL: begin
                    r_sum <= fill_sum;
                    r_cnt <= r_cnt + LEN_W'(1);
                    if (last_fill) begin
                        if (r_op == OP_FILL) begin
                            r_snap_sum <= fill_sum;
                            r_wr_idx   <= '0;
                            r_snap_idx <= '0;
                        end else begin
                            r_first  <= 1'b0;
                            r_result <= {{(RES_W - SAMPLE_BITS){r_x[SAMPLE_BITS-1]}}, r_x};
                        end
                    end
                end
                ST_COPY: begin
                    r_cnt <= r_cnt + LEN_W'(1);
                    if (last_copy) begin
                        if (r_op == OP_SAVE) begin
                            r_snap_sum <= r_sum;
                            r_snap_idx <= r_wr_idx;
                        end else begin
                            r_sum    <= r_snap_sum;
                            r_wr_idx <= r_snap_idx;
                        end
                    end
                end
                ST_UPDATE: begin
                    r_sum    <= upd_sum;
                    r_wr_idx <= nidx[IDX_W-1:0];
                    r_cnt    <= ctr[LEN_W-1:0];
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_result <= (r_filter_mode == MODE_LOWPASS) ? q_ext : ctr_ext - q_ext;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_out_filtered <= sat_out;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready     = in_ready;
    assign o_res.valid    = r_out_valid;
    assign o_res.filtered = r_out_filtered;

    a_wr_idx_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |=> (LEN_W'(r_wr_idx) < r_len))
        else $error("write pointer left the window after an update");

    a_centre_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt < r_len))
        else $error("centre index outside the window");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide step");

    a_first_cleared_by_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_first) |-> ($past(r_op) == OP_SAMPLE) && $past(r_state == ST_FILL))
        else $error("first-sample flag cleared by something other than a sample");

endmodule

`default_nettype wire
